>>> sv/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the byte-level I2C master core.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int HALF_W      = 16;
    localparam int TIMEOUT_W   = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int BYTE_W      = 8;
    localparam int BITCNT_W    = 4;
    localparam int REQ_W       = 3;

    localparam logic [HALF_W-1:0]    HALF_PERIOD_RESET = 16'd5;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE     = 4'd8;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 8'd1;

    // command codes
    localparam logic [REQ_W-1:0] REQ_NONE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RD_ACK  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RD_NACK = 3'd5;

    typedef enum logic [14:0] {
        PH_IDLE     = 15'h0001,
        PH_START_A  = 15'h0002,
        PH_START_B  = 15'h0004,
        PH_STOP_A   = 15'h0008,
        PH_STOP_B   = 15'h0010,
        PH_WR_LOW   = 15'h0020,
        PH_WR_HIGH  = 15'h0040,
        PH_WR_TAIL  = 15'h0080,
        PH_ACK_HIGH = 15'h0100,
        PH_TO_A     = 15'h0200,
        PH_TO_B     = 15'h0400,
        PH_RD_LOW   = 15'h0800,
        PH_RD_HIGH  = 15'h1000,
        PH_RACK_A   = 15'h2000,
        PH_RACK_B   = 15'h4000
    } phase_t;

    typedef struct packed {
        logic [HALF_W-1:0]    half_period;
        logic [TIMEOUT_W-1:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] tx_byte;
        logic              sda_sample;
    } tick_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_release;
        logic              busy_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              cmd_done;
        logic              ack_error;
    } result_t;

    // handshake between the pipeline stages
    typedef struct packed {
        logic advance;
    } flow_t;

endpackage

>>> sv/i2cbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cbm_cfg_regs
// Configuration registers: half bit phase length and acknowledge timeout.
// ----------------------------------------------------------------------------
module i2cbm_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output i2cbm_pkg::cfg_t                    cfg
);

    logic [i2cbm_pkg::HALF_W-1:0]    half_reg;
    logic [i2cbm_pkg::TIMEOUT_W-1:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg    <= i2cbm_pkg::HALF_PERIOD_RESET;
            timeout_reg <= i2cbm_pkg::ACK_TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            // writes beyond the register list fall through
            unique case (cfg_index)
                i2cbm_pkg::CFG_HALF_PERIOD: begin
                    half_reg <= cfg_data[i2cbm_pkg::HALF_W-1:0];
                end
                i2cbm_pkg::CFG_ACK_TIMEOUT: begin
                    timeout_reg <= cfg_data[i2cbm_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.half_period = half_reg;
    assign cfg.ack_timeout = timeout_reg;

endmodule

>>> sv/i2cbm_in_reg.sv
// ----------------------------------------------------------------------------
// i2cbm_in_reg
// Input register holding one bus tick until the engine takes it.
// ----------------------------------------------------------------------------
module i2cbm_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  i2cbm_pkg::tick_t  tick_in,
    input  logic              out_ready,
    output i2cbm_pkg::flow_t  flow,
    output i2cbm_pkg::tick_t  tick_q
);

    logic             valid_reg;
    logic             valid_next;
    i2cbm_pkg::tick_t tick_reg;
    logic             advance;

    assign advance  = valid_reg && out_ready;
    assign s_tready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg <= tick_in;
        end
    end

    assign flow.advance = advance;
    assign tick_q       = tick_reg;

endmodule

>>> sv/i2cbm_engine.sv
// ----------------------------------------------------------------------------
// i2cbm_engine
// Bus sequencer: phase machine, half phase timer, shifter and ack polling.
// One step per tick; produces the bus levels and status after the tick.
// ----------------------------------------------------------------------------
module i2cbm_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2cbm_pkg::cfg_t     cfg,
    input  i2cbm_pkg::flow_t    flow,
    input  i2cbm_pkg::tick_t    tick,
    output i2cbm_pkg::result_t  result
);

    i2cbm_pkg::phase_t phase_reg, phase_next;
    logic [i2cbm_pkg::BITCNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [i2cbm_pkg::BYTE_W-1:0]    shift_reg, shift_next;
    logic [i2cbm_pkg::HALF_W-1:0]    tick_count_reg, tick_count_next;
    logic [i2cbm_pkg::TIMEOUT_W-1:0] wait_count_reg, wait_count_next;
    logic                            scl_reg, scl_next;
    logic                            sda_reg, sda_next;
    logic                            read_ack_reg, read_ack_next;
    logic [i2cbm_pkg::BYTE_W-1:0]    rx_last_reg, rx_last_next;

    logic                            done;
    logic                            err;
    logic [i2cbm_pkg::HALF_W-1:0]    half_m1;
    logic [i2cbm_pkg::BITCNT_W-1:0]  bit_inc;
    logic [i2cbm_pkg::BYTE_W-1:0]    shift_left;

    // a zero half period behaves as one tick
    assign half_m1    = (cfg.half_period == '0) ? '0 : cfg.half_period - 1'b1;
    assign bit_inc    = bit_count_reg + 1'b1;
    assign shift_left = {shift_reg[i2cbm_pkg::BYTE_W-2:0], 1'b0};

    always_comb begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        wait_count_next = wait_count_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        read_ack_next   = read_ack_reg;
        rx_last_next    = rx_last_reg;
        done            = 1'b0;
        err             = 1'b0;

        if (phase_reg == i2cbm_pkg::PH_IDLE) begin
            unique case (tick.req_type) inside
                i2cbm_pkg::REQ_START: begin
                    phase_next      = i2cbm_pkg::PH_START_A;
                    scl_next        = 1'b1;
                    sda_next        = 1'b1;
                    tick_count_next = half_m1;
                end
                i2cbm_pkg::REQ_STOP: begin
                    phase_next      = i2cbm_pkg::PH_STOP_A;
                    scl_next        = 1'b0;
                    sda_next        = 1'b0;
                    tick_count_next = half_m1;
                end
                i2cbm_pkg::REQ_WRITE: begin
                    shift_next      = tick.tx_byte;
                    bit_count_next  = '0;
                    phase_next      = i2cbm_pkg::PH_WR_LOW;
                    scl_next        = 1'b0;
                    sda_next        = tick.tx_byte[i2cbm_pkg::BYTE_W-1];
                    tick_count_next = half_m1;
                end
                i2cbm_pkg::REQ_RD_ACK, i2cbm_pkg::REQ_RD_NACK: begin
                    read_ack_next   = (tick.req_type == i2cbm_pkg::REQ_RD_ACK);
                    shift_next      = '0;
                    bit_count_next  = '0;
                    phase_next      = i2cbm_pkg::PH_RD_LOW;
                    scl_next        = 1'b0;
                    sda_next        = 1'b1;
                    tick_count_next = half_m1;
                end
                default: begin
                end
            endcase
        end else if (tick_count_reg != '0) begin
            tick_count_next = tick_count_reg - 1'b1;
        end else begin
            // entering a phase reloads the timer; finishing clears it
            tick_count_next = half_m1;
            unique case (phase_reg) inside
                i2cbm_pkg::PH_START_A: begin
                    phase_next = i2cbm_pkg::PH_START_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                i2cbm_pkg::PH_START_B: begin
                    phase_next      = i2cbm_pkg::PH_IDLE;
                    scl_next        = 1'b0;
                    sda_next        = 1'b0;
                    tick_count_next = '0;
                    done            = 1'b1;
                end
                i2cbm_pkg::PH_STOP_A: begin
                    phase_next = i2cbm_pkg::PH_STOP_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                i2cbm_pkg::PH_STOP_B, i2cbm_pkg::PH_TO_B: begin
                    phase_next      = i2cbm_pkg::PH_IDLE;
                    scl_next        = 1'b1;
                    sda_next        = 1'b1;
                    tick_count_next = '0;
                    done            = 1'b1;
                    err             = (phase_reg == i2cbm_pkg::PH_TO_B);
                end
                i2cbm_pkg::PH_WR_LOW: begin
                    phase_next = i2cbm_pkg::PH_WR_HIGH;
                    scl_next   = 1'b1;
                end
                i2cbm_pkg::PH_WR_HIGH: begin
                    phase_next = i2cbm_pkg::PH_WR_TAIL;
                    scl_next   = 1'b0;
                end
                i2cbm_pkg::PH_WR_TAIL: begin
                    bit_count_next = bit_inc;
                    shift_next     = shift_left;
                    if (bit_inc < i2cbm_pkg::BITS_PER_BYTE) begin
                        phase_next = i2cbm_pkg::PH_WR_LOW;
                        scl_next   = 1'b0;
                        sda_next   = shift_left[i2cbm_pkg::BYTE_W-1];
                    end else begin
                        wait_count_next = '0;
                        phase_next      = i2cbm_pkg::PH_ACK_HIGH;
                        scl_next        = 1'b1;
                        sda_next        = 1'b1;
                    end
                end
                i2cbm_pkg::PH_ACK_HIGH: begin
                    if (!tick.sda_sample) begin
                        phase_next      = i2cbm_pkg::PH_IDLE;
                        scl_next        = 1'b0;
                        sda_next        = 1'b1;
                        tick_count_next = '0;
                        done            = 1'b1;
                    end else if (wait_count_reg >= cfg.ack_timeout) begin
                        // no ack in time: drive a stop of our own
                        phase_next = i2cbm_pkg::PH_TO_A;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end else begin
                        // keep polling; timer stays at zero
                        wait_count_next = wait_count_reg + 1'b1;
                        tick_count_next = tick_count_reg;
                    end
                end
                i2cbm_pkg::PH_TO_A: begin
                    phase_next = i2cbm_pkg::PH_TO_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                i2cbm_pkg::PH_RD_LOW: begin
                    phase_next     = i2cbm_pkg::PH_RD_HIGH;
                    scl_next       = 1'b1;
                    sda_next       = 1'b1;
                    shift_next     = {shift_reg[i2cbm_pkg::BYTE_W-2:0], tick.sda_sample};
                    bit_count_next = bit_inc;
                end
                i2cbm_pkg::PH_RD_HIGH: begin
                    scl_next = 1'b0;
                    if (bit_count_reg < i2cbm_pkg::BITS_PER_BYTE) begin
                        phase_next = i2cbm_pkg::PH_RD_LOW;
                        sda_next   = 1'b1;
                    end else begin
                        phase_next = i2cbm_pkg::PH_RACK_A;
                        sda_next   = !read_ack_reg;
                    end
                end
                i2cbm_pkg::PH_RACK_A: begin
                    phase_next = i2cbm_pkg::PH_RACK_B;
                    scl_next   = 1'b1;
                end
                i2cbm_pkg::PH_RACK_B: begin
                    rx_last_next    = shift_reg;
                    phase_next      = i2cbm_pkg::PH_IDLE;
                    scl_next        = 1'b0;
                    tick_count_next = '0;
                    done            = 1'b1;
                end
                default: begin
                    phase_next      = i2cbm_pkg::PH_IDLE;
                    tick_count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2cbm_pkg::PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            tick_count_reg <= '0;
            wait_count_reg <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            read_ack_reg   <= 1'b0;
            rx_last_reg    <= '0;
        end else if (flow.advance) begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            wait_count_reg <= wait_count_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            read_ack_reg   <= read_ack_next;
            rx_last_reg    <= rx_last_next;
        end
    end

    assign result.scl_level   = scl_next;
    assign result.sda_release = sda_next;
    assign result.busy_res    = (phase_next != i2cbm_pkg::PH_IDLE);
    assign result.rx_byte     = rx_last_next;
    assign result.cmd_done    = done;
    assign result.ack_error   = err;

endmodule

>>> sv/i2cbm_out_reg.sv
// ----------------------------------------------------------------------------
// i2cbm_out_reg
// Result register on the master side; holds a beat while the sink stalls.
// ----------------------------------------------------------------------------
module i2cbm_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  i2cbm_pkg::result_t  result_in,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                out_ready,
    output i2cbm_pkg::result_t  result_q
);

    logic               valid_reg;
    logic               valid_next;
    i2cbm_pkg::result_t result_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign result_q = result_reg;

endmodule

>>> sv/i2c_byte_level_master_core.sv
// ----------------------------------------------------------------------------
// i2c_byte_level_master_core
// Byte-level I2C master stepped by one bus tick per input beat.
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid/s_tready    tick: command, tx byte, sda sample
//   m_        out   m_tvalid/m_tready    bus levels and status after the tick
//   cfg_      in    cfg_valid/cfg_ready  register index and write data
//
// one beat in gives one beat out, through the input register and the result
// register; a new beat is taken every cycle while the sink keeps up.
// the phase machine and timers advance once per beat, so the bus timing is
// counted in beats, not clock cycles.
// a stall on m_ backs up through both registers to s_tready.
// reset is synchronous, active low; configuration writes are always accepted.
// ----------------------------------------------------------------------------
module i2c_byte_level_master_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,  // tx_byte[7:0], sda_sample[8]
    input  logic [2:0]                         s_tuser,  // req_type[2:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scl_level[0], sda_release[1], busy_res[2], rx_byte[10:3],
    // cmd_done[11], ack_error[12]
    output logic [15:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    i2cbm_pkg::cfg_t    cfg;
    i2cbm_pkg::tick_t   tick_in;
    i2cbm_pkg::tick_t   tick_q;
    i2cbm_pkg::flow_t   flow;
    i2cbm_pkg::result_t result;
    i2cbm_pkg::result_t result_q;
    logic               out_ready;

    assign tick_in.req_type   = s_tuser;
    assign tick_in.tx_byte    = s_tdata[7:0];
    assign tick_in.sda_sample = s_tdata[8];

    i2cbm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cbm_in_reg u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .tick_in   (tick_in),
        .out_ready (out_ready),
        .flow      (flow),
        .tick_q    (tick_q)
    );

    i2cbm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .flow    (flow),
        .tick    (tick_q),
        .result  (result)
    );

    i2cbm_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (flow.advance),
        .result_in (result),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_ready (out_ready),
        .result_q  (result_q)
    );

    assign m_tdata = {3'b000,
                      result_q.ack_error,
                      result_q.cmd_done,
                      result_q.rx_byte,
                      result_q.busy_res,
                      result_q.sda_release,
                      result_q.scl_level};

endmodule

>>> sv/i2cbm_checker.sv
// ----------------------------------------------------------------------------
// i2cbm_checker
// Port-level checks of the byte-level I2C master core.
// ----------------------------------------------------------------------------
module i2cbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a completed command leaves the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> !m_tdata[2])
        else $error("cmd_done while busy");

    // ack error only on a completion beat
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[11])
        else $error("ack_error without cmd_done");

    // timeout ends with the stop condition: both lines released
    a_err_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[0] && m_tdata[1])
        else $error("ack_error without bus released");

endmodule

bind i2c_byte_level_master_core i2cbm_checker u_i2cbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/i2c_bus_checker.sv
// ----------------------------------------------------------------------------
// i2c_bus_checker
// Watches the tick, result and register channels of the byte-level I2C
// master, runs its own copy of the bus phase machine on every accepted tick
// and compares each result beat field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module i2c_bus_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // tx_byte[7:0], sda_sample[8]
    input  logic [2:0]                        s_tuser,  // req_type[2:0]
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // scl_level[0], sda_release[1], busy_res[2], rx_byte[10:3],
    // cmd_done[11], ack_error[12]
    input  logic [15:0]                       m_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [i2cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                errors,
    output int                                outstanding,
    output logic                              bus_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [i2cbm_pkg::HALF_W-1:0]    half_cfg;
    logic [i2cbm_pkg::TIMEOUT_W-1:0] timeout_cfg;
    i2cbm_pkg::phase_t               phase;
    logic [i2cbm_pkg::BITCNT_W-1:0]  bit_cnt;
    logic [i2cbm_pkg::BYTE_W-1:0]    shreg;
    logic [i2cbm_pkg::BYTE_W-1:0]    rx_hold;
    logic [i2cbm_pkg::HALF_W-1:0]    ticks_left;
    logic [i2cbm_pkg::TIMEOUT_W-1:0] polls;
    logic                            scl_q;
    logic                            sda_q;
    logic                            ack_mode;
    i2cbm_pkg::result_t              expected_levels[$];
    int                              beat_no;

    initial begin
        errors = 0;
        outstanding = 0;
        bus_busy = 1'b0;
        beat_no = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s: got %h, expected %h",
                                      beat_no, what, got, want));
        end
    endtask

    task automatic clear_bus();
        half_cfg    = i2cbm_pkg::HALF_PERIOD_RESET;
        timeout_cfg = i2cbm_pkg::ACK_TIMEOUT_RESET;
        phase       = i2cbm_pkg::PH_IDLE;
        bit_cnt     = '0;
        shreg       = '0;
        rx_hold     = '0;
        ticks_left  = '0;
        polls       = '0;
        scl_q       = 1'b1;
        sda_q       = 1'b1;
        ack_mode    = 1'b0;
    endtask

    // a zero half period still holds each level for one tick
    task automatic enter_half(input i2cbm_pkg::phase_t ph, input logic scl,
                              input logic sda);
        phase      = ph;
        scl_q      = scl;
        sda_q      = sda;
        ticks_left = (half_cfg == '0) ? '0 : half_cfg - 1'b1;
    endtask

    task automatic end_cmd(input logic scl, input logic sda);
        phase      = i2cbm_pkg::PH_IDLE;
        scl_q      = scl;
        sda_q      = sda;
        ticks_left = '0;
    endtask

    task automatic advance_bus_tick(input logic [i2cbm_pkg::REQ_W-1:0] req,
                                    input logic [i2cbm_pkg::BYTE_W-1:0] tx,
                                    input logic sda,
                                    output i2cbm_pkg::result_t res);
        logic done;
        logic err;
        done = 1'b0;
        err  = 1'b0;
        if (phase == i2cbm_pkg::PH_IDLE) begin
            // spare codes fall through as no command
            case (req) inside
                i2cbm_pkg::REQ_START: enter_half(i2cbm_pkg::PH_START_A, 1'b1, 1'b1);
                i2cbm_pkg::REQ_STOP:  enter_half(i2cbm_pkg::PH_STOP_A, 1'b0, 1'b0);
                i2cbm_pkg::REQ_WRITE: begin
                    shreg   = tx;
                    bit_cnt = '0;
                    enter_half(i2cbm_pkg::PH_WR_LOW, 1'b0, tx[7]);
                end
                i2cbm_pkg::REQ_RD_ACK, i2cbm_pkg::REQ_RD_NACK: begin
                    ack_mode = (req == i2cbm_pkg::REQ_RD_ACK);
                    shreg    = '0;
                    bit_cnt  = '0;
                    enter_half(i2cbm_pkg::PH_RD_LOW, 1'b0, 1'b1);
                end
                default: ;
            endcase
        end else if (ticks_left != '0) begin
            ticks_left = ticks_left - 1'b1;
        end else begin
            case (phase)
                i2cbm_pkg::PH_START_A: enter_half(i2cbm_pkg::PH_START_B, 1'b1, 1'b0);
                i2cbm_pkg::PH_START_B: begin
                    end_cmd(1'b0, 1'b0);
                    done = 1'b1;
                end
                i2cbm_pkg::PH_STOP_A: enter_half(i2cbm_pkg::PH_STOP_B, 1'b1, 1'b0);
                i2cbm_pkg::PH_STOP_B: begin
                    end_cmd(1'b1, 1'b1);
                    done = 1'b1;
                end
                i2cbm_pkg::PH_WR_LOW:  enter_half(i2cbm_pkg::PH_WR_HIGH, 1'b1, sda_q);
                i2cbm_pkg::PH_WR_HIGH: enter_half(i2cbm_pkg::PH_WR_TAIL, 1'b0, sda_q);
                i2cbm_pkg::PH_WR_TAIL: begin
                    bit_cnt = bit_cnt + 1'b1;
                    shreg   = shreg << 1;
                    if (bit_cnt < i2cbm_pkg::BITS_PER_BYTE) begin
                        enter_half(i2cbm_pkg::PH_WR_LOW, 1'b0, shreg[7]);
                    end else begin
                        polls = '0;
                        enter_half(i2cbm_pkg::PH_ACK_HIGH, 1'b1, 1'b1);
                    end
                end
                i2cbm_pkg::PH_ACK_HIGH: begin
                    if (!sda) begin
                        end_cmd(1'b0, 1'b1);
                        done = 1'b1;
                    end else if (polls >= timeout_cfg) begin
                        enter_half(i2cbm_pkg::PH_TO_A, 1'b0, 1'b0);
                    end else begin
                        polls = polls + 1'b1;
                    end
                end
                i2cbm_pkg::PH_TO_A: enter_half(i2cbm_pkg::PH_TO_B, 1'b1, 1'b0);
                i2cbm_pkg::PH_TO_B: begin
                    end_cmd(1'b1, 1'b1);
                    done = 1'b1;
                    err  = 1'b1;
                end
                i2cbm_pkg::PH_RD_LOW: begin
                    enter_half(i2cbm_pkg::PH_RD_HIGH, 1'b1, 1'b1);
                    shreg   = {shreg[6:0], sda};
                    bit_cnt = bit_cnt + 1'b1;
                end
                i2cbm_pkg::PH_RD_HIGH: begin
                    if (bit_cnt < i2cbm_pkg::BITS_PER_BYTE) begin
                        enter_half(i2cbm_pkg::PH_RD_LOW, 1'b0, 1'b1);
                    end else begin
                        enter_half(i2cbm_pkg::PH_RACK_A, 1'b0, !ack_mode);
                    end
                end
                i2cbm_pkg::PH_RACK_A: enter_half(i2cbm_pkg::PH_RACK_B, 1'b1, sda_q);
                i2cbm_pkg::PH_RACK_B: begin
                    rx_hold = shreg;
                    end_cmd(1'b0, sda_q);
                    done = 1'b1;
                end
                default: end_cmd(scl_q, sda_q);
            endcase
        end
        res.scl_level   = scl_q;
        res.sda_release = sda_q;
        res.busy_res    = (phase != i2cbm_pkg::PH_IDLE);
        res.rx_byte     = rx_hold;
        res.cmd_done    = done;
        res.ack_error   = err;
    endtask

    always @(posedge aclk) begin : monitor
        i2cbm_pkg::result_t want;
        if (!aresetn) begin
            clear_bus();
            expected_levels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    i2cbm_pkg::CFG_HALF_PERIOD:
                        half_cfg = cfg_data[i2cbm_pkg::HALF_W-1:0];
                    i2cbm_pkg::CFG_ACK_TIMEOUT:
                        timeout_cfg = cfg_data[i2cbm_pkg::TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with no tick pending",
                                              m_tdata));
                end else begin
                    want = expected_levels.pop_front();
                    check_field("scl_level", 8'(m_tdata[0]), 8'(want.scl_level));
                    check_field("sda_release", 8'(m_tdata[1]), 8'(want.sda_release));
                    check_field("busy_res", 8'(m_tdata[2]), 8'(want.busy_res));
                    check_field("rx_byte", m_tdata[10:3], want.rx_byte);
                    check_field("cmd_done", 8'(m_tdata[11]), 8'(want.cmd_done));
                    check_field("ack_error", 8'(m_tdata[12]), 8'(want.ack_error));
                    check_field("padding", 8'(m_tdata[15:13]), 8'h00);
                end
                beat_no++;
            end
            if (s_tvalid && s_tready) begin
                advance_bus_tick(s_tuser, s_tdata[7:0], s_tdata[8], want);
                expected_levels.push_back(want);
            end
        end
        outstanding <= expected_levels.size();
        bus_busy    <= (phase != i2cbm_pkg::PH_IDLE);
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bus ticks and register writes into the byte-level I2C master:
// directed commands and corner settings first, then random transactions
// (start, address, data reads and writes, stop) with stray commands mixed
// in, under several timing settings and backpressure profiles.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [i2cbm_pkg::REQ_W-1:0]       REQ_SPARE_A     = 3'd6;
    localparam logic [i2cbm_pkg::REQ_W-1:0]       REQ_SPARE_B     = 3'd7;
    localparam logic [i2cbm_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED    = 8'd2;
    localparam logic [i2cbm_pkg::CFG_INDEX_W-1:0] CFG_TOP_INDEX   = 8'hFF;
    localparam int                                TICKS_PER_PHASE = 90;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic [15:0]                       s_tdata   = '0;
    logic [2:0]                        s_tuser   = i2cbm_pkg::REQ_NONE;
    logic                              m_tready  = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic [i2cbm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [i2cbm_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                              s_tready;
    logic                              m_tvalid;
    logic [15:0]                       m_tdata;
    logic                              cfg_ready;
    int                                errors;
    int                                outstanding;
    logic                              bus_busy;

    int send_gap   = 24;
    int recv_stall = 63;
    int ticks_sent = 0;

    i2c_byte_level_master_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_bus_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .bus_busy    (bus_busy)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    initial begin
        #2ms;
        $display("testbench failed");
        $finish;
    end

    // valid stays high from one beat to the next unless a gap is drawn
    task automatic push_tick(input logic [i2cbm_pkg::REQ_W-1:0] req,
                             input logic [7:0] tx, input logic sda);
        while ($urandom_range(99) < send_gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, sda, tx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    // bus_busy lags by one beat, so the first follow-up tick always goes out;
    // follow-up ticks carry stray commands now and then, ignored while busy
    task automatic run_cmd(input logic [i2cbm_pkg::REQ_W-1:0] req,
                           input logic [7:0] tx, input int sda_low_pct);
        push_tick(req, tx, 1'($urandom_range(1)));
        do begin
            push_tick(($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                               : i2cbm_pkg::REQ_NONE,
                      8'($urandom), ($urandom_range(99) >= sda_low_pct));
        end while (bus_busy);
    endtask

    task automatic write_reg(input logic [i2cbm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [i2cbm_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // mostly a quick acknowledge, sometimes a slow slave, sometimes none
    function automatic int pick_ack();
        int r;
        r = $urandom_range(9);
        return (r < 7) ? 50 : ((r < 9) ? 5 : 0);
    endfunction

    task automatic random_transaction();
        int n;
        if ($urandom_range(9) == 0) begin
            run_cmd(3'($urandom_range(7)), 8'($urandom), pick_ack());
        end else begin
            n = $urandom_range(1, 2);
            run_cmd(i2cbm_pkg::REQ_START, 8'($urandom), 50);
            run_cmd(i2cbm_pkg::REQ_WRITE, 8'($urandom), pick_ack());
            repeat (n) begin
                if ($urandom_range(1)) begin
                    run_cmd(i2cbm_pkg::REQ_WRITE, 8'($urandom), pick_ack());
                end else begin
                    run_cmd(i2cbm_pkg::REQ_RD_ACK, 8'($urandom), 50);
                end
            end
            if ($urandom_range(1)) run_cmd(i2cbm_pkg::REQ_RD_NACK, 8'($urandom), 50);
            run_cmd(i2cbm_pkg::REQ_STOP, 8'($urandom), 50);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: plain and spare codes while idle, then a short exchange
        push_tick(i2cbm_pkg::REQ_NONE, 8'h00, 1'b0);
        push_tick(REQ_SPARE_A, 8'hFF, 1'b1);
        push_tick(REQ_SPARE_B, 8'h5A, 1'b0);
        run_cmd(i2cbm_pkg::REQ_START, 8'h00, 50);
        run_cmd(i2cbm_pkg::REQ_WRITE, 8'hA5, 50);
        run_cmd(i2cbm_pkg::REQ_RD_NACK, 8'hFF, 50);
        run_cmd(i2cbm_pkg::REQ_STOP, 8'h00, 50);

        // zero timeout: first high poll already times out
        drain();
        write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'd1);
        write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, 16'h0000);
        run_cmd(i2cbm_pkg::REQ_WRITE, 8'h81, 0);
        run_cmd(i2cbm_pkg::REQ_WRITE, 8'h7E, 100);
        run_cmd(i2cbm_pkg::REQ_WRITE, 8'hFF, 50);
        run_cmd(i2cbm_pkg::REQ_WRITE, 8'h00, 50);
        // read issued right behind a write is dropped
        push_tick(i2cbm_pkg::REQ_WRITE, 8'h3C, 1'b1);
        run_cmd(i2cbm_pkg::REQ_RD_ACK, 8'h00, 50);

        drain();
        write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'h0000);
        run_cmd(i2cbm_pkg::REQ_START, 8'h00, 50);
        run_cmd(i2cbm_pkg::REQ_RD_NACK, 8'h00, 50);
        run_cmd(i2cbm_pkg::REQ_STOP, 8'h00, 50);

        drain();
        write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'h0020);
        run_cmd(i2cbm_pkg::REQ_STOP, 8'h00, 50);

        // writes to unmapped indexes must leave the timing alone
        drain();
        write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'd2);
        write_reg(CFG_UNMAPPED, 16'h0009);
        write_reg(CFG_TOP_INDEX, 16'h0001);
        run_cmd(i2cbm_pkg::REQ_START, 8'h00, 50);
        run_cmd(i2cbm_pkg::REQ_STOP, 8'h00, 50);

        for (int p = 0; p < 6; p++) begin
            int target;
            drain();
            case (p)
                0: begin
                    write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'd1);
                    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, {8'($urandom), 8'd3});
                end
                1: begin
                    write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'd0);
                    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, {8'($urandom), 8'd0});
                end
                2: begin
                    write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'd2);
                    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, {8'($urandom), 8'd255});
                end
                3: begin
                    write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'd3);
                    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, {8'($urandom), 8'd1});
                end
                4: begin
                    write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'd1);
                    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, {8'($urandom), 8'd250});
                    write_reg(CFG_UNMAPPED, 16'($urandom));
                end
                default: begin
                    write_reg(i2cbm_pkg::CFG_HALF_PERIOD, 16'($urandom_range(1, 3)));
                    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT,
                              {8'($urandom), 8'($urandom_range(1, 40))});
                end
            endcase
            if (p < 2) begin
                send_gap   = 24;
                recv_stall = 63;
            end else if (p < 4) begin
                send_gap   = 63;
                recv_stall = 24;
            end else begin
                send_gap   = 0;
                recv_stall = 0;
            end
            target = ticks_sent + TICKS_PER_PHASE;
            while (ticks_sent < target) random_transaction();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0 && outstanding == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> i2c_byte_level_master_core.f
sv/i2cbm_pkg.sv
sv/i2cbm_cfg_regs.sv
sv/i2cbm_in_reg.sv
sv/i2cbm_engine.sv
sv/i2cbm_out_reg.sv
sv/i2c_byte_level_master_core.sv
sv/i2cbm_checker.sv
test/i2c_bus_checker.sv
test/testbench.sv
